// ----- rtl/core/signed_divide_remainder_macros.svh -----
// Assertion macros shared by the signed divider RTL.
`ifndef SIGNED_DIVIDE_REMAINDER_MACROS_SVH
`define SIGNED_DIVIDE_REMAINDER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SDR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("signed_divide_remainder: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("signed_divide_remainder: next-cycle check failed");
`else
`define SDR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SDR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/sdr_pkg.sv -----
// Shared constants and types for the signed divider.
package sdr_pkg;

    // Width of every data port, fixed by the interface.
    localparam int PORT_WIDTH = 64;

    // Per-transaction control that rides along the divider pipeline.
    typedef struct packed {
        logic q_neg;     // Negate the quotient at the end.
        logic r_neg;     // Negate the remainder at the end.
        logic zero_div;  // Divisor was zero.
        logic ovf;       // Minimum value divided by minus one.
    } sdr_flags_t;

endpackage

// ----- rtl/core/signed_divide_remainder.sv -----
// Top level of the pipelined signed 64-bit divide with remainder.
//
// Usage: the input channel (in_valid/in_ready) carries one dividend and one
// divisor per transaction; the output channel (out_valid/out_ready) returns
// the quotient (truncated toward zero), the remainder (sign of the dividend)
// and two flags. Only the low DATA_WIDTH bits of each operand are used, and
// output bits above DATA_WIDTH are zero.
// Division by zero gives an all-ones quotient, the dividend as remainder and
// zero_divisor set. The minimum value divided by minus one gives the minimum
// value as quotient, a zero remainder and overflowed set.
// The pipeline has one input stage that takes magnitudes, DATA_WIDTH
// restoring-division stages that each settle one quotient bit with a
// DATA_WIDTH + 1 bit subtract, and one output stage that restores the
// signs. Throughput is one transaction per cycle unless the receiver stalls.
// When the receiver stalls, the whole pipeline holds in place and in_ready
// drops in the same cycle, so no transaction is lost or repeated.
// Reset clears every stage's valid bit; the pipeline is empty after reset.
`include "signed_divide_remainder_macros.svh"

module signed_divide_remainder
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PORT_WIDTH-1:0] dividend,
    input  logic [PORT_WIDTH-1:0] divisor,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PORT_WIDTH-1:0] quotient,
    output logic [PORT_WIDTH-1:0] remainder,
    output logic                  zero_divisor,
    output logic                  overflowed
);

    localparam logic [DATA_WIDTH-1:0] SIGN_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

    // A single enable moves every stage at once; it is low only while the
    // output register holds a transaction that the receiver has not taken.
    logic advance;

    // Input stage: operand magnitudes and the sign bookkeeping.
    logic                  a_valid_reg;
    logic [DATA_WIDTH-1:0] ua_reg;
    logic [DATA_WIDTH-1:0] ub_reg;
    sdr_flags_t            a_flags_reg;

    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic [DATA_WIDTH-1:0] ua_next;
    logic [DATA_WIDTH-1:0] ub_next;
    sdr_flags_t            a_flags_next;

    // Divider chain: index 0 is the input stage, index k the k-th step.
    logic                  chain_valid [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] chain_rem   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] chain_quo   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] chain_dvsr  [DATA_WIDTH+1];
    sdr_flags_t            chain_flags [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] div_valid;

    // Output stage.
    logic                  o_valid_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic                  zero_reg;
    logic                  ovf_reg;

    logic [DATA_WIDTH-1:0] quo_next;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] q_mag;
    logic [DATA_WIDTH-1:0] r_mag;
    sdr_flags_t            fin_flags;

    assign advance  = !o_valid_reg || out_ready;
    assign in_ready = advance;

    // The minimum value negates to itself, which is its correct magnitude
    // when read as unsigned.
    always_comb
    begin
        op_a    = dividend[DATA_WIDTH-1:0];
        op_b    = divisor[DATA_WIDTH-1:0];
        ua_next = op_a[DATA_WIDTH-1] ? (~op_a + DATA_WIDTH'(1)) : op_a;
        ub_next = op_b[DATA_WIDTH-1] ? (~op_b + DATA_WIDTH'(1)) : op_b;
        a_flags_next.q_neg    = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
        a_flags_next.r_neg    = op_a[DATA_WIDTH-1];
        a_flags_next.zero_div = (op_b == '0);
        a_flags_next.ovf      = (op_a == SIGN_MIN) && (op_b == ALL_ONES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ua_reg      <= ua_next;
            ub_reg      <= ub_next;
            a_flags_reg <= a_flags_next;
        end
    end

    // The dividend magnitude enters through the quotient register and is
    // shifted into the partial remainder one bit per step.
    assign chain_valid[0] = a_valid_reg;
    assign chain_rem[0]   = '0;
    assign chain_quo[0]   = ua_reg;
    assign chain_dvsr[0]  = ub_reg;
    assign chain_flags[0] = a_flags_reg;

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_step
        sdr_div_stage #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (chain_valid[k]),
            .in_rem    (chain_rem[k]),
            .in_quo    (chain_quo[k]),
            .in_dvsr   (chain_dvsr[k]),
            .in_flags  (chain_flags[k]),
            .out_valid (chain_valid[k+1]),
            .out_rem   (chain_rem[k+1]),
            .out_quo   (chain_quo[k+1]),
            .out_dvsr  (chain_dvsr[k+1]),
            .out_flags (chain_flags[k+1])
        );
        assign div_valid[k] = chain_valid[k+1];
    end

    // Sign restoration. With a zero divisor the step chain yields the
    // dividend magnitude as remainder, so only the quotient is overridden.
    always_comb
    begin
        q_mag     = chain_quo[DATA_WIDTH];
        r_mag     = chain_rem[DATA_WIDTH];
        fin_flags = chain_flags[DATA_WIDTH];
        if (fin_flags.zero_div)
        begin
            quo_next = ALL_ONES;
        end
        else if (fin_flags.q_neg)
        begin
            quo_next = ~q_mag + DATA_WIDTH'(1);
        end
        else
        begin
            quo_next = q_mag;
        end
        rem_next = fin_flags.r_neg ? (~r_mag + DATA_WIDTH'(1)) : r_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            o_valid_reg <= chain_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            zero_reg <= fin_flags.zero_div;
            ovf_reg  <= fin_flags.ovf;
        end
    end

    assign out_valid    = o_valid_reg;
    assign quotient     = PORT_WIDTH'(quo_reg);
    assign remainder    = PORT_WIDTH'(rem_reg);
    assign zero_divisor = zero_reg;
    assign overflowed   = ovf_reg;

    // The two special cases exclude each other.
    `SDR_ASSERT_IMPLIES(a_flags_exclusive, clk, rst_n, out_valid, !(zero_divisor && overflowed))
    // Division by zero always reports an all-ones quotient.
    `SDR_ASSERT_IMPLIES(a_zero_quotient, clk, rst_n, out_valid && zero_divisor, quotient == PORT_WIDTH'(ALL_ONES))
    // The overflow case leaves nothing over.
    `SDR_ASSERT_IMPLIES(a_ovf_remainder, clk, rst_n, out_valid && overflowed, remainder == '0)
    // A stall freezes the occupancy of every divider step.
    `SDR_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !in_ready, $stable(div_valid))

endmodule

// ----- rtl/core/sdr_div_stage.sv -----
// One registered restoring-division step of the signed divider pipeline.
module sdr_div_stage
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DATA_WIDTH-1:0] in_rem,
    input  logic [DATA_WIDTH-1:0] in_quo,
    input  logic [DATA_WIDTH-1:0] in_dvsr,
    input  sdr_flags_t            in_flags,
    output logic                  out_valid,
    output logic [DATA_WIDTH-1:0] out_rem,
    output logic [DATA_WIDTH-1:0] out_quo,
    output logic [DATA_WIDTH-1:0] out_dvsr,
    output sdr_flags_t            out_flags
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] dvsr_reg;
    sdr_flags_t            flags_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] quo_next;

    // A nonzero divisor keeps the partial remainder below it, so shifted fits in one extra bit.
    always_comb
    begin
        shifted = {in_rem, in_quo[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, in_dvsr};
        if (diff[DATA_WIDTH] == 1'b0)
        begin
            rem_next = diff[DATA_WIDTH-1:0];
            quo_next = {in_quo[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DATA_WIDTH-1:0];
            quo_next = {in_quo[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            dvsr_reg  <= in_dvsr;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_dvsr  = dvsr_reg;
    assign out_flags = flags_reg;

endmodule
